// ===== src/ckmc_pkg.sv =====
// Package with the item types, key and mode codes and edit-field helpers of the key controller.
`timescale 1ns / 1ps

package ckmc_pkg;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MS_MAX   = 6'd59;

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_NEXT  = 3'd1,
    KEY_HR    = 3'd2,
    KEY_MIN   = 3'd3,
    KEY_SEC   = 3'd4,
    KEY_SS    = 3'd5,
    KEY_CLR   = 3'd6
  } key_e;

  typedef enum logic [4:0] {
    ST_SHOW   = 5'b00001,
    ST_SET    = 5'b00010,
    ST_SWIDLE = 5'b00100,
    ST_SWRUN  = 5'b01000,
    ST_ALARM  = 5'b10000
  } ui_state_e;

  localparam logic [2:0] MODE_SHOW   = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_SWIDLE = 3'd2;
  localparam logic [2:0] MODE_SWRUN  = 3'd3;
  localparam logic [2:0] MODE_ALM    = 3'd4;

  localparam logic [1:0] SRC_CLOCK = 2'd0;
  localparam logic [1:0] SRC_EDIT  = 2'd1;
  localparam logic [1:0] SRC_SW    = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] cur_hour;
    logic [5:0] cur_min;
    logic [5:0] cur_sec;
  } in_item_t;

  typedef struct packed {
    logic [2:0] current_mode;
    logic [1:0] display_source;
    logic [4:0] disp_hour;
    logic [5:0] disp_min;
    logic [5:0] disp_sec;
    logic       time_write;
    logic       alarm_write;
    logic [4:0] commit_hour;
    logic [5:0] commit_min;
    logic [5:0] commit_sec;
    logic       sw_clear;
    logic       sw_running;
  } out_item_t;

  function automatic logic [4:0] inc_hour(input logic [4:0] v);
    inc_hour = (v >= HOUR_MAX) ? 5'd0 : v + 5'd1;
  endfunction

  function automatic logic [5:0] inc_ms(input logic [5:0] v);
    inc_ms = (v >= MS_MAX) ? 6'd0 : v + 6'd1;
  endfunction

endpackage

// ===== src/ckmc_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps

interface ckmc_in_if;
  logic               valid;
  logic               ready;
  ckmc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ckmc_out_if;
  logic                valid;
  logic                ready;
  ckmc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/ckmc_in_stage.sv =====
// Input register stage that holds one accepted key item until the core takes it.
`timescale 1ns / 1ps

module ckmc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ckmc_pkg::in_item_t in_data_i,
  output logic               in_ready_o,
  input  logic               take_i,
  output logic               st_valid_o,
  output ckmc_pkg::in_item_t st_data_o
);

  logic               valid_q;
  logic               valid_d;
  ckmc_pkg::in_item_t data_q;
  logic               load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign st_valid_o = valid_q;
  assign st_data_o  = data_q;

endmodule

// ===== src/ckmc_core.sv =====
// Mode state machine and edit registers that turn one key item into one result item.
`timescale 1ns / 1ps

module ckmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  ckmc_pkg::in_item_t  item_i,
  output ckmc_pkg::out_item_t res_o
);

  ckmc_pkg::ui_state_e state_q, state_d;
  logic [4:0] edit_hour_q, edit_hour_d;
  logic [5:0] edit_min_q, edit_min_d;
  logic [5:0] edit_sec_q, edit_sec_d;
  ckmc_pkg::key_e key;
  logic twr, awr, swc;
  logic [4:0] kh;
  logic [5:0] km, ks;

  assign key = ckmc_pkg::key_e'(item_i.mode);

  always_comb begin
    state_d     = state_q;
    edit_hour_d = edit_hour_q;
    edit_min_d  = edit_min_q;
    edit_sec_d  = edit_sec_q;
    twr = 1'b0;
    awr = 1'b0;
    swc = 1'b0;
    kh  = '0;
    km  = '0;
    ks  = '0;
    unique case (state_q) inside
      ckmc_pkg::ST_SET, ckmc_pkg::ST_ALARM: begin
        if (key == ckmc_pkg::KEY_NEXT) begin
          twr = (state_q == ckmc_pkg::ST_SET);
          awr = (state_q == ckmc_pkg::ST_ALARM);
          kh  = edit_hour_q;
          km  = edit_min_q;
          ks  = edit_sec_q;
          state_d = (state_q == ckmc_pkg::ST_SET) ? ckmc_pkg::ST_SWIDLE : ckmc_pkg::ST_SHOW;
        end else if (key == ckmc_pkg::KEY_HR) begin
          edit_hour_d = ckmc_pkg::inc_hour(edit_hour_q);
        end else if (key == ckmc_pkg::KEY_MIN) begin
          edit_min_d = ckmc_pkg::inc_ms(edit_min_q);
        end else if (key == ckmc_pkg::KEY_SEC) begin
          edit_sec_d = ckmc_pkg::inc_ms(edit_sec_q);
        end
      end
      ckmc_pkg::ST_SWIDLE, ckmc_pkg::ST_SWRUN: begin
        if (key == ckmc_pkg::KEY_SS) begin
          swc = (state_q == ckmc_pkg::ST_SWIDLE);
          state_d = (state_q == ckmc_pkg::ST_SWIDLE) ? ckmc_pkg::ST_SWRUN :
                    ckmc_pkg::ST_SWIDLE;
        end else if (key == ckmc_pkg::KEY_CLR) begin
          swc = (state_q == ckmc_pkg::ST_SWRUN);
        end else if (key == ckmc_pkg::KEY_NEXT) begin
          swc = 1'b1;
          edit_hour_d = '0;
          edit_min_d  = '0;
          edit_sec_d  = '0;
          state_d = ckmc_pkg::ST_ALARM;
        end
      end
      default: begin
        state_d = ckmc_pkg::ST_SHOW;
        if (key == ckmc_pkg::KEY_NEXT) begin
          edit_hour_d = item_i.cur_hour;
          edit_min_d  = item_i.cur_min;
          edit_sec_d  = item_i.cur_sec;
          state_d = ckmc_pkg::ST_SET;
        end
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    res_o.time_write  = twr;
    res_o.alarm_write = awr;
    res_o.commit_hour = kh;
    res_o.commit_min  = km;
    res_o.commit_sec  = ks;
    res_o.sw_clear    = swc;
    res_o.sw_running  = (state_d == ckmc_pkg::ST_SWRUN);
    unique case (state_d) inside
      ckmc_pkg::ST_SET, ckmc_pkg::ST_ALARM: begin
        res_o.current_mode   = (state_d == ckmc_pkg::ST_SET) ? ckmc_pkg::MODE_SET :
                               ckmc_pkg::MODE_ALM;
        res_o.display_source = ckmc_pkg::SRC_EDIT;
        res_o.disp_hour      = edit_hour_d;
        res_o.disp_min       = edit_min_d;
        res_o.disp_sec       = edit_sec_d;
      end
      ckmc_pkg::ST_SWIDLE, ckmc_pkg::ST_SWRUN: begin
        res_o.current_mode   = (state_d == ckmc_pkg::ST_SWIDLE) ? ckmc_pkg::MODE_SWIDLE :
                               ckmc_pkg::MODE_SWRUN;
        res_o.display_source = ckmc_pkg::SRC_SW;
      end
      default: begin
        res_o.current_mode   = ckmc_pkg::MODE_SHOW;
        res_o.display_source = ckmc_pkg::SRC_CLOCK;
        res_o.disp_hour      = item_i.cur_hour;
        res_o.disp_min       = item_i.cur_min;
        res_o.disp_sec       = item_i.cur_sec;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ckmc_pkg::ST_SHOW;
      edit_hour_q <= '0;
      edit_min_q  <= '0;
      edit_sec_q  <= '0;
    end else if (take_i) begin
      state_q     <= state_d;
      edit_hour_q <= edit_hour_d;
      edit_min_q  <= edit_min_d;
      edit_sec_q  <= edit_sec_d;
    end
  end

endmodule

// ===== src/ckmc_out_stage.sv =====
// Result register that holds one result item until the consumer takes it.
`timescale 1ns / 1ps

module ckmc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                st_valid_i,
  input  ckmc_pkg::out_item_t res_i,
  output logic                take_o,
  output logic                out_valid_o,
  output ckmc_pkg::out_item_t out_data_o,
  input  logic                out_ready_i
);

  logic                valid_q;
  logic                valid_d;
  ckmc_pkg::out_item_t data_q;

  assign take_o  = st_valid_i && (!valid_q || out_ready_i);
  assign valid_d = take_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/clock_key_mode_controller_top.sv =====
// Top level of the clock key controller: input register, mode core and result register.
// Each key item is registered in the input register, and its result in the result register.
// Throughput: one item per cycle while the consumer is ready; the input register and the
// result register each accept a new item in the cycle their current item moves on.
// Reset clears both stage valid bits, sets the mode to show time and the edit fields to zero.
`timescale 1ns / 1ps

module clock_key_mode_controller_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  ckmc_in_if.sink          in_i,
  ckmc_out_if.source       out_o
);

  logic                st_valid;
  logic                take;
  ckmc_pkg::in_item_t  st_data;
  ckmc_pkg::out_item_t res;
  logic                in_ready;
  logic                out_valid;
  ckmc_pkg::out_item_t out_data;

  ckmc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_ready),
    .take_i     (take),
    .st_valid_o (st_valid),
    .st_data_o  (st_data)
  );

  ckmc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (st_data),
    .res_o  (res)
  );

  ckmc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_valid_i  (st_valid),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data.time_write && out_data.alarm_write))
    else $error("Time and alarm commit raised together.");

  a_run_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.sw_running == (out_data.current_mode == ckmc_pkg::MODE_SWRUN)))
    else $error("Stopwatch run level disagrees with the mode.");

  a_sw_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.display_source == ckmc_pkg::SRC_SW) |->
      (out_data.disp_hour == '0 && out_data.disp_min == '0 && out_data.disp_sec == '0))
    else $error("Stopwatch display carries time digits.");

  a_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_data.time_write && !out_data.alarm_write) |->
      (out_data.commit_hour == '0 && out_data.commit_min == '0 && out_data.commit_sec == '0))
    else $error("Commit fields are set without a commit.");

endmodule
